### hw/rtl/bstp_pkg.sv
// Shared types, sizes and 3x3 pattern tables for the skeleton thinning pass.
// Used by bstp_front, bstp_back and binary_skeleton_thinning_pass_core.
package bstp_pkg;

    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 1024;
    localparam int COL_W      = $clog2(MAX_WIDTH);
    localparam int ROW_W      = $clog2(MAX_HEIGHT + 3);
    localparam int DIM_W      = 11;
    localparam int GRAY_W     = 8;
    localparam int CNT_W      = 21;
    localparam int IDX_W      = 2;
    localparam int MID_DEPTH  = 4;
    localparam int MID_PTR_W  = $clog2(MID_DEPTH);
    localparam int OUT_DEPTH  = 2;
    localparam int OUT_PTR_W  = $clog2(OUT_DEPTH);
    localparam int COND_COUNT   = 40;
    localparam int UNCOND_COUNT = 26;

    localparam logic [DIM_W-1:0]  RST_WIDTH  = DIM_W'(512);
    localparam logic [DIM_W-1:0]  RST_HEIGHT = DIM_W'(512);
    localparam logic [GRAY_W-1:0] RST_THRESH = GRAY_W'(128);

    typedef enum logic [IDX_W-1:0] {
        REG_WIDTH  = 2'd0,
        REG_HEIGHT = 2'd1,
        REG_THRESH = 2'd2
    } t_reg_idx;

    // One classified request from the front to the back.
    typedef struct packed {
        logic             adv;    // request advances the stream position
        logic             pix;    // binarized pixel at the new position
        logic             int_m;  // mark center is interior
        logic             int_t;  // output center is interior
        logic             outv;   // request yields an output pixel
        logic             last;   // request yields the frame's last pixel
        logic [COL_W-1:0] col;    // line buffer address of this position
        logic [COL_W-1:0] ncol;   // line buffer address of the next position
    } t_fe_entry;

    typedef struct packed {
        logic             valid;
        logic             pixel;
        logic             last;
        logic [CNT_W-1:0] erased;
    } t_result;

    // Window bit order: top-left first, MSB.
    localparam logic [8:0] COND_PAT [COND_COUNT] = '{
        9'b010011000, 9'b010110000, 9'b000110010, 9'b000011010,
        9'b001011001, 9'b111010000, 9'b100110100, 9'b000010111,
        9'b111011000, 9'b011011001, 9'b111110000, 9'b110110100,
        9'b100110110, 9'b000110111, 9'b000011111, 9'b001011011,
        9'b111011001, 9'b111110100, 9'b100110111, 9'b001011111,
        9'b011011011, 9'b111111000, 9'b110110110, 9'b000111111,
        9'b111011011, 9'b011011111, 9'b111111100, 9'b111111001,
        9'b111110110, 9'b110110111, 9'b100111111, 9'b001111111,
        9'b111011111, 9'b111111101, 9'b111110111, 9'b101111111,
        9'b111111011, 9'b111111110, 9'b110111111, 9'b011111111
    };

    localparam logic [8:0] UNC_CARE [UNCOND_COUNT] = '{
        9'b111111111, 9'b111111111, 9'b111111111, 9'b111111111,
        9'b111111111, 9'b111111111, 9'b111111111, 9'b111111111,
        9'b111111111, 9'b111111111, 9'b111111111, 9'b111111111,
        9'b110110000, 9'b000011011,
        9'b010111000, 9'b010110010, 9'b000111010, 9'b010011010,
        9'b101010000, 9'b100010100, 9'b000010101, 9'b001010001,
        9'b011111110, 9'b110111011, 9'b011111110, 9'b110111011
    };

    localparam logic [8:0] UNC_VAL [UNCOND_COUNT] = '{
        9'b000010001, 9'b000010100, 9'b001010000, 9'b100010000,
        9'b000010010, 9'b000011000, 9'b000110000, 9'b010010000,
        9'b010011000, 9'b010110000, 9'b000011010, 9'b000110010,
        9'b110110000, 9'b000011011,
        9'b010111000, 9'b010110010, 9'b000111010, 9'b010011010,
        9'b101010000, 9'b100010100, 9'b000010101, 9'b001010001,
        9'b010011100, 9'b010110001, 9'b001110010, 9'b100011010
    };

    // Positions of which at least one must be set.
    localparam logic [8:0] UNC_ANY [UNCOND_COUNT] = '{
        9'b000000000, 9'b000000000, 9'b000000000, 9'b000000000,
        9'b000000000, 9'b000000000, 9'b000000000, 9'b000000000,
        9'b000000000, 9'b000000000, 9'b000000000, 9'b000000000,
        9'b000000000, 9'b000000000,
        9'b000000000, 9'b000000000, 9'b000000000, 9'b000000000,
        9'b000000111, 9'b001001001, 9'b111000000, 9'b100100100,
        9'b000000000, 9'b000000000, 9'b000000000, 9'b000000000
    };

    function automatic logic cond_hit(input logic [8:0] w);
        logic hit;
        hit = 1'b0;
        for (int p = 0; p < COND_COUNT; p++) begin
            if (w == COND_PAT[p]) hit = 1'b1;
        end
        return hit;
    endfunction

    function automatic logic uncond_hit(input logic [8:0] w);
        logic hit;
        hit = 1'b0;
        for (int p = 0; p < UNCOND_COUNT; p++) begin
            if (((w & UNC_CARE[p]) == UNC_VAL[p]) &&
                ((UNC_ANY[p] == 9'b0) || ((w & UNC_ANY[p]) != 9'b0))) hit = 1'b1;
        end
        return hit;
    endfunction

endpackage

### hw/rtl/bstp_front.sv
// Front part: configuration registers, stream position tracking, request
// classification and the short queue toward the back. Depends on bstp_pkg.
module bstp_front (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [bstp_pkg::IDX_W-1:0]    i_cfg_idx,
    input  logic [bstp_pkg::DIM_W-1:0]    i_cfg_data,
    input  logic                          push,
    output logic                          full,
    input  logic                          i_kind,
    input  logic [bstp_pkg::GRAY_W-1:0]   i_gray,
    output logic                          o_ent_vld,
    output bstp_pkg::t_fe_entry           o_ent,
    input  logic                          i_ent_take
);

    logic [bstp_pkg::DIM_W-1:0]  r_cfg_w, r_cfg_h;
    logic [bstp_pkg::GRAY_W-1:0] r_thresh;
    logic                        r_active;
    logic [bstp_pkg::DIM_W-1:0]  r_w, r_h;
    logic [bstp_pkg::COL_W-1:0]  r_col;
    logic [bstp_pkg::ROW_W-1:0]  r_row;

    bstp_pkg::t_fe_entry r_q [bstp_pkg::MID_DEPTH];
    logic [bstp_pkg::MID_PTR_W-1:0] r_wp, r_rp;
    logic [bstp_pkg::MID_PTR_W:0]   r_cnt;

    logic [bstp_pkg::DIM_W-1:0] clamp_w, clamp_h, eff_w, eff_h;
    logic [bstp_pkg::COL_W-1:0] eff_wm1;
    logic [bstp_pkg::ROW_W-1:0] h_m1, h_p1, h_p2;
    logic                       accept, in_frame, adv, last, col_end;
    logic [bstp_pkg::COL_W-1:0] n_col;
    logic [bstp_pkg::ROW_W-1:0] n_row;
    bstp_pkg::t_fe_entry        ent;

    always_comb begin
        if (r_cfg_w < bstp_pkg::DIM_W'(3)) clamp_w = bstp_pkg::DIM_W'(3);
        else if (r_cfg_w > bstp_pkg::DIM_W'(bstp_pkg::MAX_WIDTH))
            clamp_w = bstp_pkg::DIM_W'(bstp_pkg::MAX_WIDTH);
        else clamp_w = r_cfg_w;
        if (r_cfg_h < bstp_pkg::DIM_W'(3)) clamp_h = bstp_pkg::DIM_W'(3);
        else if (r_cfg_h > bstp_pkg::DIM_W'(bstp_pkg::MAX_HEIGHT))
            clamp_h = bstp_pkg::DIM_W'(bstp_pkg::MAX_HEIGHT);
        else clamp_h = r_cfg_h;

        eff_w   = r_active ? r_w : clamp_w;
        eff_h   = r_active ? r_h : clamp_h;
        eff_wm1 = bstp_pkg::COL_W'(eff_w - 1'b1);
        h_m1    = bstp_pkg::ROW_W'(eff_h) - 1'b1;
        h_p1    = bstp_pkg::ROW_W'(eff_h) + 1'b1;
        h_p2    = bstp_pkg::ROW_W'(eff_h) + 2'd2;

        full     = (r_cnt == (bstp_pkg::MID_PTR_W+1)'(bstp_pkg::MID_DEPTH));
        accept   = push && !full;
        in_frame = (r_row < bstp_pkg::ROW_W'(eff_h));
        adv      = r_active ? !(in_frame && i_kind) : !i_kind;
        last     = (r_row == h_p2) && (r_col == bstp_pkg::COL_W'(1));
        col_end  = (r_col == eff_wm1);

        n_col = (last || col_end) ? '0 : r_col + 1'b1;
        n_row = last ? '0 : (col_end ? r_row + 1'b1 : r_row);

        ent.adv   = adv;
        ent.pix   = in_frame && !i_kind && (i_gray >= r_thresh);
        ent.int_m = (r_col >= bstp_pkg::COL_W'(2)) && (r_row >= bstp_pkg::ROW_W'(2)) &&
                    (r_row <= h_m1);
        ent.int_t = ((r_col == '0) && (r_row >= bstp_pkg::ROW_W'(4)) && (r_row <= h_p1)) ||
                    ((r_col >= bstp_pkg::COL_W'(3)) && (r_row >= bstp_pkg::ROW_W'(3)) &&
                     (r_row <= bstp_pkg::ROW_W'(eff_h)));
        ent.outv  = (r_row >= bstp_pkg::ROW_W'(3)) ||
                    ((r_row == bstp_pkg::ROW_W'(2)) && (r_col >= bstp_pkg::COL_W'(2)));
        ent.last  = last;
        ent.col   = r_col;
        ent.ncol  = n_col;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_w  <= bstp_pkg::RST_WIDTH;
            r_cfg_h  <= bstp_pkg::RST_HEIGHT;
            r_thresh <= bstp_pkg::RST_THRESH;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                bstp_pkg::REG_WIDTH:  r_cfg_w  <= i_cfg_data;
                bstp_pkg::REG_HEIGHT: r_cfg_h  <= i_cfg_data;
                bstp_pkg::REG_THRESH: r_thresh <= i_cfg_data[bstp_pkg::GRAY_W-1:0];
                default: ;
            endcase
        end
    end

    // Latch frame size at the first pixel; sizes hold for the whole frame.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
            r_col    <= '0;
            r_row    <= '0;
            r_w      <= bstp_pkg::DIM_W'(3);
            r_h      <= bstp_pkg::DIM_W'(3);
        end else if (accept && adv) begin
            if (!r_active) begin
                r_w <= clamp_w;
                r_h <= clamp_h;
            end
            r_active <= !last;
            r_col    <= n_col;
            r_row    <= n_row;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) r_q[r_wp] <= ent;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (accept) r_wp <= r_wp + 1'b1;
            if (i_ent_take) r_rp <= r_rp + 1'b1;
            r_cnt <= r_cnt + (bstp_pkg::MID_PTR_W+1)'(accept)
                           - (bstp_pkg::MID_PTR_W+1)'(i_ent_take);
        end
    end

    assign o_ent_vld = (r_cnt != '0);
    assign o_ent     = r_q[r_rp];

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= (bstp_pkg::MID_PTR_W+1)'(bstp_pkg::MID_DEPTH))
        else $error("front queue overflow");
    a_idle_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_active |-> (r_col == '0 && r_row == '0))
        else $error("position not cleared while idle");
    a_col_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_active |-> (r_col <= bstp_pkg::COL_W'(r_w - 1'b1)))
        else $error("column beyond frame width");

endmodule

### hw/rtl/bstp_back.sv
// Back part: line buffer memory, image and mark windows, pattern matching,
// erase counting and the result queue. Depends on bstp_pkg.
module bstp_back (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_ent_vld,
    input  bstp_pkg::t_fe_entry   i_ent,
    output logic                  o_ent_take,
    output logic                  empty,
    input  logic                  pop,
    output bstp_pkg::t_result     o_res
);

    // Entry bits: {image two rows up, image one row up, mark two up, mark one up}
    logic [3:0] r_line [bstp_pkg::MAX_WIDTH];
    logic [3:0] r_rd;
    logic [2:0] r_ia, r_ib, r_ma, r_mb;
    logic [bstp_pkg::CNT_W-1:0] r_erased;

    bstp_pkg::t_result r_oq [bstp_pkg::OUT_DEPTH];
    logic [bstp_pkg::OUT_PTR_W-1:0] r_owp, r_orp;
    logic [bstp_pkg::OUT_PTR_W:0]   r_ocnt;

    logic [2:0] icol, mcol;
    logic [8:0] iwin, mwin;
    logic       mk, erase, do_pop;
    logic [bstp_pkg::CNT_W-1:0] cnt_next;
    bstp_pkg::t_result res;

    always_comb begin
        o_ent_take = i_ent_vld && (r_ocnt != (bstp_pkg::OUT_PTR_W+1)'(bstp_pkg::OUT_DEPTH));
        icol = {r_rd[3], r_rd[2], i_ent.pix};
        iwin = {r_ia[2], r_ib[2], icol[2], r_ia[1], r_ib[1], icol[1],
                r_ia[0], r_ib[0], icol[0]};
        mk   = i_ent.int_m && bstp_pkg::cond_hit(iwin);
        mcol = {r_rd[1], r_rd[0], mk};
        mwin = {r_ma[2], r_mb[2], mcol[2], r_ma[1], r_mb[1], mcol[1],
                r_ma[0], r_mb[0], mcol[0]};
        erase    = i_ent.adv && i_ent.int_t && r_mb[1] && !bstp_pkg::uncond_hit(mwin);
        cnt_next = r_erased + bstp_pkg::CNT_W'(erase);

        res.valid  = i_ent.adv && i_ent.outv;
        res.pixel  = res.valid && r_ia[2] && !erase;
        res.last   = res.valid && i_ent.last;
        res.erased = cnt_next;
        do_pop     = pop && !empty;
    end

    always_ff @(posedge i_clk) begin
        if (o_ent_take && i_ent.adv) begin
            r_line[i_ent.col] <= {r_rd[2], i_ent.pix, r_rd[0], mk};
            r_rd <= r_line[i_ent.ncol];
            r_ia <= r_ib;
            r_ib <= icol;
            r_ma <= r_mb;
            r_mb <= mcol;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_erased <= '0;
        end else if (o_ent_take && i_ent.adv) begin
            r_erased <= res.last ? '0 : cnt_next;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ent_take) r_oq[r_owp] <= res;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_owp  <= '0;
            r_orp  <= '0;
            r_ocnt <= '0;
        end else begin
            if (o_ent_take) r_owp <= r_owp + 1'b1;
            if (do_pop) r_orp <= r_orp + 1'b1;
            r_ocnt <= r_ocnt + (bstp_pkg::OUT_PTR_W+1)'(o_ent_take)
                             - (bstp_pkg::OUT_PTR_W+1)'(do_pop);
        end
    end

    assign empty = (r_ocnt == '0);
    assign o_res = r_oq[r_orp];

    a_ocnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ocnt <= (bstp_pkg::OUT_PTR_W+1)'(bstp_pkg::OUT_DEPTH))
        else $error("result queue overflow");
    a_last_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_ent_take && res.last) |=> (r_erased == '0))
        else $error("erase count not cleared after frame end");
    a_addr_differ: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_ent_take && i_ent.adv) |-> (i_ent.col != i_ent.ncol))
        else $error("line buffer read and write collide");

endmodule

### hw/rtl/binary_skeleton_thinning_pass_core.sv
// One binary thinning pass over a raster pixel stream: binarize, conditional
// mark, unconditional keep test. Top level; uses bstp_pkg, bstp_front, bstp_back.
//
// Usage: write image_width (0), image_height (1) and gray_threshold (2) while
// idle. Push one pixel request per pushed item (kind 0) in raster order, then
// 2*W+2 flush requests (kind 1). Every accepted request yields one result:
// results lag the pixels by 2*W+2 requests, out_valid marks those that carry
// a pixel, frame_last marks the frame's last pixel, erased_total is the
// running erase count of the frame and drops to zero after frame_last.
// Throughput is one request per cycle while full stays low; the simple
// dual-port line buffer does one read and one write per request. With both
// queues empty an accepted request is registered in the front queue, then
// its result in the result queue, from which it can be popped.
// Reset clears the queues, the position and the count and restores register
// defaults; the line buffer needs no clearing pass. When pop stays low the
// result queue (2 deep) fills, the back stops, the front queue (4 deep) fills
// and full rises; nothing is dropped.
module binary_skeleton_thinning_pass_core (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [bstp_pkg::IDX_W-1:0]    i_cfg_idx,
    input  logic [bstp_pkg::DIM_W-1:0]    i_cfg_data,
    input  logic                          push,
    output logic                          full,
    input  logic                          i_kind,
    input  logic [bstp_pkg::GRAY_W-1:0]   i_gray,
    output logic                          empty,
    input  logic                          pop,
    output logic                          o_out_valid,
    output logic                          o_out_pixel,
    output logic                          o_frame_last,
    output logic [bstp_pkg::CNT_W-1:0]    o_erased_total
);

    logic                ent_vld, ent_take;
    bstp_pkg::t_fe_entry ent;
    bstp_pkg::t_result   res;

    bstp_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .push       (push),
        .full       (full),
        .i_kind     (i_kind),
        .i_gray     (i_gray),
        .o_ent_vld  (ent_vld),
        .o_ent      (ent),
        .i_ent_take (ent_take)
    );

    bstp_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ent_vld  (ent_vld),
        .i_ent      (ent),
        .o_ent_take (ent_take),
        .empty      (empty),
        .pop        (pop),
        .o_res      (res)
    );

    assign o_out_valid    = res.valid;
    assign o_out_pixel    = res.pixel;
    assign o_frame_last   = res.last;
    assign o_erased_total = res.erased;

endmodule
